@@ rtl/core/sha_pkg.sv @@
// Shared types, round constants and round functions for the SHA-256 stream core.
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned HASH_WORDS = 8;

  localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;

  localparam logic [31:0] SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic load;
    logic shift;
    logic expand;
    logic round;
  } sha_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

@@ rtl/core/sha_if.sv @@
// Valid/ready channel interfaces for message words and digest words.
`timescale 1ns / 1ps
interface sha_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, output data_word, output byte_count, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last_word,
                output ready);
endinterface

interface sha_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_index, output digest_last,
                  input ready);
  modport sink (input valid, input digest_word, input digest_index, input digest_last,
                output ready);
endinterface

@@ rtl/core/sha_sched.sv @@
// Message schedule: a row of sixteen word cells that shift toward cell 0 each step.
`timescale 1ns / 1ps
module sha_sched (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  input  logic [31:0]       push_word,
  output logic [31:0]       w_cur
);

  logic [31:0] w [sha_pkg::BLOCK_WORDS];
  logic [31:0] w_new;
  logic [31:0] tail;

  // W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
  assign w_new = sha_pkg::ssig1(w[14]) + w[9] + sha_pkg::ssig0(w[1]) + w[0];
  assign tail  = ctl.expand ? w_new : push_word;
  assign w_cur = w[0];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
        w[i] <= w[i + 1];
      end
      w[sha_pkg::BLOCK_WORDS - 1] <= tail;
    end
  end

endmodule

@@ rtl/core/sha_round.sv @@
// Compression round unit: working registers a..h chained one round per cycle.
`timescale 1ns / 1ps
module sha_round (
  input  logic              clk,
  input  sha_pkg::sha_ctl_t ctl,
  input  logic [31:0]       chain [sha_pkg::HASH_WORDS],
  input  logic [31:0]       k,
  input  logic [31:0]       w,
  output logic [31:0]       vars [sha_pkg::HASH_WORDS]
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1  = vars[7] + sha_pkg::bsig1(vars[4]) + ch + k + w;
  assign t2  = sha_pkg::bsig0(vars[0]) + maj;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
        vars[i] <= chain[i];
      end
    end else if (ctl.round) begin
      vars[0] <= t1 + t2;
      vars[1] <= vars[0];
      vars[2] <= vars[1];
      vars[3] <= vars[2];
      vars[4] <= vars[3] + t1;
      vars[5] <= vars[4];
      vars[6] <= vars[5];
      vars[7] <= vars[6];
    end
  end

endmodule

@@ rtl/core/sha256_stream_hash_core.sv @@
// Top level of the streaming SHA-256 core: word packing, padding, control and digest output.
`timescale 1ns / 1ps
// Usage:
//   msg carries message words, first byte in bits 31..24, byte_count valid
//   bytes from the top (counts above four act as four), last_word on the final
//   word. A word is taken when valid and ready are high at a clock edge.
//   digest returns eight words, digest_index 0..7, digest_last on word 7.
// Block flow: a word that does not complete a block is taken without a stall. The
//   sixteenth word of a block starts 64 rounds plus one chain update, during
//   which intake waits; the single round unit sets the pace of each block.
// Finish: after the last word, padding pushes one word per cycle, pausing while a
//   filled block compresses and once before the two length words; each block
//   filled on the way (one or two) then runs its rounds and chain update. Digest
//   words leave at one per cycle while digest.ready holds, from an output register
//   loaded in S_OUT from the updated chain.
// msg.ready is high only between messages and during plain word intake; it
//   drops from the last word until the final digest word sits in the output
//   register. A stalled digest word holds; the core waits on it.
// Reset (rst, synchronous) loads the initial hash values, clears the bit
//   count and drops all valids. After each digest the core re-arms itself.
module sha256_stream_hash_core (
  input logic          clk,
  input logic          rst,
  sha_msg_if.sink      msg,
  sha_digest_if.source digest
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LENHI = 3'd3;
  localparam logic [2:0] S_LENLO = 3'd4;
  localparam logic [2:0] S_COMP  = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [3:0] LEN_SLOT  = 4'd14;
  localparam logic [3:0] LAST_SLOT = 4'd15;
  localparam logic [5:0] LAST_RND  = 6'd63;
  localparam logic [2:0] LAST_IDX  = 3'd7;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [2:0]  ret;
  logic [2:0]  ret_next;
  logic [3:0]  wcnt;
  logic [3:0]  wcnt_next;
  logic [23:0] pend;
  logic [23:0] pend_next;
  logic [1:0]  pcnt;
  logic [1:0]  pcnt_next;
  logic [5:0]  rnd;
  logic [2:0]  oidx;
  logic [63:0] bit_count;
  logic [31:0] chain [sha_pkg::HASH_WORDS];
  logic [31:0] vars [sha_pkg::HASH_WORDS];
  logic [31:0] w_cur;
  logic [31:0] round_k;

  logic        push;
  logic [31:0] push_word;
  logic        acc;
  logic        out_load;
  logic [2:0]  cnt_sat;
  logic [31:0] data_mask;
  logic [55:0] comb;
  logic [2:0]  ntot;

  logic        out_valid;
  logic [31:0] out_word;
  logic [2:0]  out_idx;
  logic        out_last;

  sha_pkg::sha_ctl_t ctl;

  assign msg.ready = (state == S_IDLE);
  assign acc       = msg.valid && msg.ready;
  assign out_load  = (state == S_OUT) && (!out_valid || digest.ready);

  assign cnt_sat = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

  always_comb begin
    case (cnt_sat)
      3'd0: begin
        data_mask = 32'h0000_0000;
      end
      3'd1: begin
        data_mask = 32'hff00_0000;
      end
      3'd2: begin
        data_mask = 32'hffff_0000;
      end
      3'd3: begin
        data_mask = 32'hffff_ff00;
      end
      default: begin
        data_mask = 32'hffff_ffff;
      end
    endcase
  end

  // pending bytes on top, new bytes appended right after them
  assign comb = {pend, 32'h0} | ({msg.data_word & data_mask, 24'h0} >> {pcnt, 3'b000});
  assign ntot = {1'b0, pcnt} + cnt_sat;

  always_comb begin
    state_next = state;
    ret_next   = ret;
    wcnt_next  = wcnt;
    pend_next  = pend;
    pcnt_next  = pcnt;
    push       = 1'b0;
    push_word  = comb[55:24];
    case (state)
      S_IDLE: begin
        if (acc) begin
          pcnt_next = ntot[1:0];
          if (ntot[2]) begin
            push      = 1'b1;
            pend_next = comb[23:0];
          end else begin
            pend_next = comb[55:32];
          end
          if (msg.last_word) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        push       = 1'b1;
        push_word  = {pend, 8'h00} | (sha_pkg::PAD_MARK_WORD >> {pcnt, 3'b000});
        pend_next  = 24'h0;
        pcnt_next  = 2'd0;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        if (wcnt != LEN_SLOT) begin
          push      = 1'b1;
          push_word = 32'h0;
        end else begin
          state_next = S_LENHI;
        end
      end
      S_LENHI: begin
        push       = 1'b1;
        push_word  = bit_count[63:32];
        state_next = S_LENLO;
      end
      S_LENLO: begin
        push       = 1'b1;
        push_word  = bit_count[31:0];
        state_next = S_OUT;
      end
      S_COMP: begin
        if (rnd == LAST_RND) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        state_next = ret;
      end
      S_OUT: begin
        if (out_load && (oidx == LAST_IDX)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // a push into the last slot fills the block and starts compression
    if (push) begin
      if (wcnt == LAST_SLOT) begin
        wcnt_next  = 4'd0;
        ret_next   = state_next;
        state_next = S_COMP;
      end else begin
        wcnt_next = wcnt + 4'd1;
      end
    end
  end

  assign ctl.load   = push && (wcnt == LAST_SLOT);
  assign ctl.shift  = push || (state == S_COMP);
  assign ctl.expand = (state == S_COMP);
  assign ctl.round  = (state == S_COMP);
  assign round_k    = sha_pkg::ROUND_K[rnd];

  sha_sched u_sched (
    .clk       (clk),
    .ctl       (ctl),
    .push_word (push_word),
    .w_cur     (w_cur)
  );

  sha_round u_round (
    .clk   (clk),
    .ctl   (ctl),
    .chain (chain),
    .k     (round_k),
    .w     (w_cur),
    .vars  (vars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      wcnt      <= 4'd0;
      pend      <= 24'h0;
      pcnt      <= 2'd0;
      rnd       <= 6'd0;
      oidx      <= 3'd0;
      bit_count <= 64'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
        chain[i] <= sha_pkg::SHA_IV[i];
      end
    end else begin
      state <= state_next;
      ret   <= ret_next;
      wcnt  <= wcnt_next;
      pend  <= pend_next;
      pcnt  <= pcnt_next;
      if (acc) begin
        bit_count <= bit_count + {58'd0, cnt_sat, 3'b000};
      end
      if (state == S_COMP) begin
        rnd <= rnd + 6'd1;
      end
      if (state == S_FINAL) begin
        for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
        oidx      <= oidx + 3'd1;
        if (oidx == LAST_IDX) begin
          bit_count <= 64'd0;
          for (int i = 0; i < sha_pkg::HASH_WORDS; i++) begin
            chain[i] <= sha_pkg::SHA_IV[i];
          end
        end
      end else if (digest.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word <= chain[oidx];
      out_idx  <= oidx;
      out_last <= (oidx == LAST_IDX);
    end
  end

  assign digest.valid        = out_valid;
  assign digest.digest_word  = out_word;
  assign digest.digest_index = out_idx;
  assign digest.digest_last  = out_last;

endmodule

@@ rtl/core/sha_chk.sv @@
// Port-level assertions for the SHA-256 stream core, bound to the top level.
`timescale 1ns / 1ps
module sha_chk (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_ready,
  input logic        msg_last,
  input logic        dig_valid,
  input logic        dig_ready,
  input logic [31:0] dig_word,
  input logic [2:0]  dig_index,
  input logic        dig_last
);

  localparam logic [2:0] LAST_IDX = 3'd7;

  a_reset_idle: assert property (@(posedge clk) rst |=> !dig_valid)
    else $error("digest valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_ready) |=> (dig_valid && $stable(dig_word) && $stable(dig_index)))
    else $error("stalled digest word changed");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig_last == (dig_index == LAST_IDX)))
    else $error("digest_last does not match index");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && !dig_last) |=>
      (!dig_valid || (dig_index == $past(dig_index) + 3'd1)))
    else $error("digest index skipped");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && msg_ready && msg_last) |=> !msg_ready)
    else $error("input taken before digest of previous message");

endmodule

bind sha256_stream_hash_core sha_chk u_sha_chk (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg.valid),
  .msg_ready (msg.ready),
  .msg_last  (msg.last_word),
  .dig_valid (digest.valid),
  .dig_ready (digest.ready),
  .dig_word  (digest.digest_word),
  .dig_index (digest.digest_index),
  .dig_last  (digest.digest_last)
);
